>>> src/bwms_pkg.sv
// ----------------------------------------------------------------------------
// bwms_pkg: shared types and constants of the binary window majority smoother
// Window column layout, result payload, register map and geometry limits.
// ----------------------------------------------------------------------------
package bwms_pkg;

  // line store depth, widest frame supported
  localparam int MaxWidth = 1024;
  localparam int ColAddrW = $clog2(MaxWidth);
  // column counter also has to hold the width itself during the flush
  localparam int ColCntW  = $clog2(MaxWidth + 1);

  localparam int FrameWidthW  = 11;
  localparam int FrameHeightW = 12;
  localparam int ThrW         = 4;
  localparam int SumW         = 4;
  localparam int MinDim       = 3;

  localparam logic [FrameWidthW-1:0]  FrameWidthRst  = FrameWidthW'(64);
  localparam logic [FrameHeightW-1:0] FrameHeightRst = FrameHeightW'(64);
  localparam logic [ThrW-1:0]         OpenThrRst     = ThrW'(5);

  // stored columns of the 3x3 window; the newest column is formed on the fly
  localparam int WinCells = 2;

  localparam int PaddrW = 4;
  localparam int PdataW = 32;

  typedef enum logic [PaddrW-3:0] {
    RegFrameWidth  = 2'd0,
    RegFrameHeight = 2'd1,
    RegOpenThr     = 2'd2
  } reg_idx_e;

  // one window column: rows r-2, r-1 and r
  typedef struct packed {
    logic cur;
    logic mid;
    logic top;
  } win_col_t;

  typedef struct packed {
    logic cell_out;
    logic frame_end;
  } res_t;

  function automatic logic [1:0] col_count(win_col_t col);
    return 2'(col.top) + 2'(col.mid) + 2'(col.cur);
  endfunction

  // width clamped to 3..MaxWidth
  function automatic logic [ColCntW-1:0] eff_width(logic [FrameWidthW-1:0] fw);
    if (int'(fw) < MinDim) return ColCntW'(MinDim);
    if (int'(fw) > MaxWidth) return ColCntW'(MaxWidth);
    return ColCntW'(fw);
  endfunction

  function automatic logic [FrameHeightW-1:0] eff_height(logic [FrameHeightW-1:0] fh);
    if (int'(fh) < MinDim) return FrameHeightW'(MinDim);
    return fh;
  endfunction

endpackage

>>> src/bwms_if.sv
// ----------------------------------------------------------------------------
// bwms_if: request channels of the binary window majority smoother
// Input cell channel and smoothed result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bwms_in_if;
  logic valid;
  logic ready;
  logic cell_in;
  logic is_pad;

  modport source (output valid, output cell_in, output is_pad, input ready);
  modport sink   (input valid, input cell_in, input is_pad, output ready);
endinterface

interface bwms_out_if;
  logic valid;
  logic ready;
  logic cell_out;
  logic frame_end;

  modport source (output valid, output cell_out, output frame_end, input ready);
  modport sink   (input valid, input cell_out, input frame_end, output ready);
endinterface

>>> src/binary_window_majority_smoother_unit.sv
// ----------------------------------------------------------------------------
// binary_window_majority_smoother_unit: 3x3 majority smoother, raster stream
// Line stores for the two rows above, a chain of window column cells, a
// popcount/threshold per cell and a registered output with skid entry.
// ----------------------------------------------------------------------------
// Output: results are registered in the output stage and trail the input
//   by one row plus one cell.
// Throughput: one request per cycle while the skid entry is free, set by the
//   line stores read one column ahead; each request finds its column ready.
// Reset: counters, registers (64, 64, 5) and output valids clear at once;
//   line stores are not cleared, a row is only read after it was written.
module binary_window_majority_smoother_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bwms_pkg::PaddrW-1:0]   paddr,
  input  logic [bwms_pkg::PdataW-1:0]   pwdata,
  output logic [bwms_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  bwms_in_if.sink                       in_i,
  bwms_out_if.source                    out_o
);

  localparam int ColCntW = bwms_pkg::ColCntW;
  localparam int RowW    = bwms_pkg::FrameHeightW;

  // configuration registers
  logic [bwms_pkg::FrameWidthW-1:0]  frame_width_q;
  logic [bwms_pkg::FrameHeightW-1:0] frame_height_q;
  logic [bwms_pkg::ThrW-1:0]         open_threshold_q;
  logic                              cfg_we;
  logic                              cfg_hit;

  logic [ColCntW-1:0] width;
  logic [RowW-1:0]    height;

  // frame position
  logic [ColCntW-1:0] col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [ColCntW-1:0] col_inc;

  logic in_acc, in_phase, flush, advance, emit, pass, push, buf_ready;
  logic upper_rd, lower_rd, top_bit, mid_bit;
  logic [bwms_pkg::SumW-1:0] win_sum;

  bwms_pkg::win_col_t new_col;
  bwms_pkg::win_col_t chain [bwms_pkg::WinCells+1];
  logic [1:0]         cnt [bwms_pkg::WinCells];
  bwms_pkg::res_t     res;

  assign pready = 1'b1;
  // writes outside the register map leave the frame running
  assign cfg_we = psel && penable && pwrite && cfg_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q    <= bwms_pkg::FrameWidthRst;
      frame_height_q   <= bwms_pkg::FrameHeightRst;
      open_threshold_q <= bwms_pkg::OpenThrRst;
    end else if (cfg_we) begin
      unique case (paddr[bwms_pkg::PaddrW-1:2])
        bwms_pkg::RegFrameWidth:  frame_width_q    <= pwdata[bwms_pkg::FrameWidthW-1:0];
        bwms_pkg::RegFrameHeight: frame_height_q   <= pwdata[bwms_pkg::FrameHeightW-1:0];
        bwms_pkg::RegOpenThr:     open_threshold_q <= pwdata[bwms_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_hit = 1'b1;
    unique case (paddr[bwms_pkg::PaddrW-1:2])
      bwms_pkg::RegFrameWidth:  prdata = bwms_pkg::PdataW'(frame_width_q);
      bwms_pkg::RegFrameHeight: prdata = bwms_pkg::PdataW'(frame_height_q);
      bwms_pkg::RegOpenThr:     prdata = bwms_pkg::PdataW'(open_threshold_q);
      default: begin
        prdata  = '0;
        cfg_hit = 1'b0;
      end
    endcase
  end

  assign width  = bwms_pkg::eff_width(frame_width_q);
  assign height = bwms_pkg::eff_height(frame_height_q);

  // rows past the last one are the flush: one request per remaining result
  assign in_phase = row_q < height;
  assign flush    = !in_phase;
  assign in_i.ready = buf_ready;
  assign in_acc   = in_i.valid && in_i.ready;
  assign advance  = in_acc && (flush || !in_i.is_pad);
  assign col_inc  = col_q + ColCntW'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we) begin
      col_d = '0;
      row_d = '0;
    end else if (advance) begin
      if (flush) begin
        if (col_q == width) begin
          col_d = '0;
          row_d = '0;
        end else begin
          col_d = col_inc;
        end
      end else if (col_inc == width) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        col_d = col_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // even rows in the upper store, odd rows in the lower; read the next column
  bwms_line_ram u_upper (
    .clk_i   (clk_i),
    .we_i    (advance && in_phase && !row_q[0]),
    .waddr_i (col_q[bwms_pkg::ColAddrW-1:0]),
    .wdata_i (in_i.cell_in),
    .raddr_i (col_d[bwms_pkg::ColAddrW-1:0]),
    .rdata_o (upper_rd)
  );

  bwms_line_ram u_lower (
    .clk_i   (clk_i),
    .we_i    (advance && in_phase && row_q[0]),
    .waddr_i (col_q[bwms_pkg::ColAddrW-1:0]),
    .wdata_i (in_i.cell_in),
    .raddr_i (col_d[bwms_pkg::ColAddrW-1:0]),
    .rdata_o (lower_rd)
  );

  assign top_bit = (row_q >= RowW'(2)) && (row_q[0] ? lower_rd : upper_rd);
  assign mid_bit = (row_q != '0) && (row_q[0] ? upper_rd : lower_rd);

  assign new_col.top  = top_bit;
  assign new_col.mid  = mid_bit;
  assign new_col.cur  = in_i.cell_in;
  assign chain[0]     = new_col;

  for (genvar k = 0; k < bwms_pkg::WinCells; k++) begin : g_cell
    bwms_col_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (advance),
      .col_i   (chain[k]),
      .col_o   (chain[k+1]),
      .cnt_o   (cnt[k])
    );
  end

  // centre is the middle of the previous column; left edge drops the oldest
  always_comb begin
    win_sum = bwms_pkg::SumW'(bwms_pkg::col_count(new_col)) + bwms_pkg::SumW'(cnt[0]);
    if (col_q != ColCntW'(1)) begin
      win_sum = win_sum + bwms_pkg::SumW'(cnt[bwms_pkg::WinCells-1]);
    end
  end

  assign emit = (row_q >= RowW'(2)) || (row_q == RowW'(1) && col_q != '0);
  // last column and last row pass through
  assign pass = flush || col_q == '0;
  assign push = advance && (flush || emit);

  assign res.cell_out  = pass ? chain[1].mid : (win_sum >= bwms_pkg::SumW'(open_threshold_q));
  assign res.frame_end = flush && col_q == width;

  bwms_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res),
    .ready_o (buf_ready),
    .out_o   (out_o)
  );

endmodule

>>> src/bwms_line_ram.sv
// ----------------------------------------------------------------------------
// bwms_line_ram: one-bit line store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bwms_line_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [bwms_pkg::ColAddrW-1:0] waddr_i,
  input  logic                          wdata_i,
  input  logic [bwms_pkg::ColAddrW-1:0] raddr_i,
  output logic                          rdata_o
);

  logic mem_q [bwms_pkg::MaxWidth];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/bwms_col_cell.sv
// ----------------------------------------------------------------------------
// bwms_col_cell: window column cell
// Holds one column of the 3x3 window, passes it on each shift, counts its
// open cells.
// ----------------------------------------------------------------------------
module bwms_col_cell (
  input  logic                       clk_i,
  input  logic                       shift_i,
  input  bwms_pkg::win_col_t         col_i,
  output bwms_pkg::win_col_t         col_o,
  output logic [1:0]                 cnt_o
);

  bwms_pkg::win_col_t col_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;
  assign cnt_o = bwms_pkg::col_count(col_q);

endmodule

>>> src/bwms_out_buf.sv
// ----------------------------------------------------------------------------
// bwms_out_buf: result output stage
// Output register plus skid entry, so the input side can push one more
// result while a result waits.
// ----------------------------------------------------------------------------
module bwms_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  bwms_pkg::res_t        res_i,
  output logic                  ready_o,
  bwms_out_if.source            out_o
);

  logic           out_valid_q, out_valid_d;
  logic           skid_valid_q, skid_valid_d;
  bwms_pkg::res_t out_q, out_d;
  bwms_pkg::res_t skid_q, skid_d;
  logic           pop;

  assign pop = out_valid_q && out_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push_i) begin
      skid_d       = res_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign ready_o         = !skid_valid_q;
  assign out_o.valid     = out_valid_q;
  assign out_o.cell_out  = out_q.cell_out;
  assign out_o.frame_end = out_q.frame_end;

endmodule
